>>> rtl/core/msw_pkg.sv
// Shared constants, types and codes of the minimum-variance window search.
package msw_pkg;

    localparam int MAX_SAMPLES = 512;
    localparam int SMP_W       = 16;
    localparam int LEN_W       = 10;
    localparam int OUT_NUM_W   = 50;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int S_W         = SMP_W + CNT_W;
    localparam int SQ_W        = 2 * SMP_W + CNT_W;
    localparam int NUM_RAW_W   = CNT_W + SQ_W;
    localparam int NUM_W       = (NUM_RAW_W > OUT_NUM_W) ? NUM_RAW_W : OUT_NUM_W + 1;
    localparam int LSQ_W       = 2 * CNT_W;
    localparam int PROD_W      = NUM_W + LSQ_W;
    localparam int CMP_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int DRAIN_CYC   = 6;
    localparam int DRN_W       = $clog2(DRAIN_CYC + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic [SMP_W-1:0] x;
        logic [CNT_W-1:0] len;
    } win_item_t;

    typedef struct packed {
        logic             vld;
        logic [NUM_W-1:0] num;
        logic [CNT_W-1:0] len;
        logic [LSQ_W-1:0] lsq;
    } cand_t;

endpackage

>>> rtl/core/msw_if.sv
// Handshake channel interfaces: sample input, result output, configuration write.
interface msw_in_if;
    logic                       valid;
    logic                       ready;
    logic [msw_pkg::SMP_W-1:0]  sample;
    logic                       last;
    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface msw_out_if;
    logic                          valid;
    logic                          ready;
    logic [msw_pkg::OUT_NUM_W-1:0] var_numerator;
    logic [msw_pkg::LEN_W-1:0]     window_len;
    logic                          valid_res;
    modport source (output valid, output var_numerator, output window_len,
                    output valid_res, input ready);
    modport sink   (input valid, input var_numerator, input window_len,
                    input valid_res, output ready);
endinterface

interface msw_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [msw_pkg::LEN_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/msw_cell.sv
// One sample cell of the circular storage chain.
module msw_cell (
    input  logic                      clk,
    input  logic                      shift,
    input  logic [msw_pkg::SMP_W-1:0] d,
    output logic [msw_pkg::SMP_W-1:0] q
);
    import msw_pkg::*;

    logic [SMP_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/core/msw_window.sv
// Running sums and variance numerator pipeline for the window stream.
module msw_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  msw_pkg::win_item_t        item,
    input  logic [msw_pkg::CMP_W-1:0] k,
    output msw_pkg::cand_t            cand
);
    import msw_pkg::*;

    logic               vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic               first1_reg;
    logic [SMP_W-1:0]   x1_reg;
    logic [2*SMP_W-1:0] xx1_reg;
    logic [CNT_W-1:0]   len1_reg, len2_reg, len3_reg, len4_reg;
    logic [S_W-1:0]     s_reg, s_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [NUM_RAW_W-1:0] p1_w;
    logic [2*S_W-1:0]   p2_w;
    logic [LSQ_W-1:0]   lsq_w;
    logic [NUM_W-1:0]   p1_reg;
    logic [2*S_W-1:0]   p2_reg;
    logic [LSQ_W-1:0]   lsq3_reg, lsq4_reg;
    logic [NUM_W-1:0]   num_reg;

    assign s_next  = first1_reg ? S_W'(x1_reg) : s_reg + S_W'(x1_reg);
    assign sq_next = first1_reg ? SQ_W'(xx1_reg) : sq_reg + SQ_W'(xx1_reg);
    assign p1_w    = len2_reg * sq_reg;
    assign p2_w    = s_reg * s_reg;
    assign lsq_w   = len2_reg * len2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= item.vld;
            vld2_reg <= vld1_reg && (CMP_W'(len1_reg) >= k);
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= item.first;
        x1_reg     <= item.x;
        xx1_reg    <= item.x * item.x;
        len1_reg   <= item.len;
        if (vld1_reg)
        begin
            s_reg  <= s_next;
            sq_reg <= sq_next;
        end
        len2_reg <= len1_reg;
        p1_reg   <= NUM_W'(p1_w);
        p2_reg   <= p2_w;
        lsq3_reg <= lsq_w;
        len3_reg <= len2_reg;
        num_reg  <= p1_reg - NUM_W'(p2_reg);
        lsq4_reg <= lsq3_reg;
        len4_reg <= len3_reg;
    end

    assign cand.vld = vld4_reg;
    assign cand.num = num_reg;
    assign cand.len = len4_reg;
    assign cand.lsq = lsq4_reg;

endmodule

>>> rtl/core/msw_best.sv
// Best-window tracker with exact cross-multiplied variance compare.
module msw_best (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clr,
    input  msw_pkg::cand_t            cand,
    output logic [msw_pkg::NUM_W-1:0] best_num,
    output logic [msw_pkg::CNT_W-1:0] best_len
);
    import msw_pkg::*;

    logic             found_reg;
    logic [NUM_W-1:0] num_reg;
    logic [CNT_W-1:0] len_reg;
    logic [LSQ_W-1:0] lsq_reg;
    logic [PROD_W-1:0] a_w, b_w;
    logic             take;

    assign a_w  = cand.num * lsq_reg;
    assign b_w  = num_reg * cand.lsq;
    assign take = cand.vld && (!found_reg || (a_w < b_w));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            num_reg   <= '0;
            len_reg   <= '0;
            lsq_reg   <= '0;
        end
        else if (clr)
        begin
            found_reg <= 1'b0;
            num_reg   <= '0;
            len_reg   <= '0;
            lsq_reg   <= '0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
            num_reg   <= cand.num;
            len_reg   <= cand.len;
            lsq_reg   <= cand.lsq;
        end
    end

    assign best_num = num_reg;
    assign best_len = len_reg;

endmodule

>>> rtl/core/min_variance_window_search.sv
// Top level of the minimum-variance contiguous window search.
//
//  channel | dir | fields                                  | transaction
//  smp     | in  | sample, last                            | one sample
//  res     | out | var_numerator, window_len, valid_res    | one search result
//  cfg     | in  | data (min_len)                          | one register write
//
//  During loading smp is always ready; samples shift into a ring of MAX_SAMPLES cells.
//  The search rotates the ring once per start position, then a drain state empties
//  the numerator pipeline, and then the result is held in ST_OUT until res takes it.
//  smp is not ready during search and drain and while the result waits on res.
//  Reset clears control state and sets min_len to 1; cell contents are not reset.
module min_variance_window_search (
    input  logic       clk,
    input  logic       rst_n,
    msw_in_if.sink     smp,
    msw_out_if.source  res,
    msw_cfg_if.sink    cfg
);
    import msw_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, n_reg, i_reg, t_reg;
    logic [DRN_W-1:0] drn_reg;
    logic [LEN_W-1:0] min_len_reg;
    logic [SMP_W-1:0] cell_q [MAX_SAMPLES];
    logic [SMP_W-1:0] ring_in;
    logic             ring_shift;
    logic             in_acc, store_ok, pass_end, last_pass;
    logic [CNT_W-1:0] off_w, n_new;
    logic [CNT_W:0]   base_w, t_ext;
    logic [CMP_W-1:0] k_w;
    win_item_t        item;
    cand_t            cand;
    logic [NUM_W-1:0] best_num;
    logic [CNT_W-1:0] best_len;
    logic [CNT_W+LEN_W-1:0] len_ext;

    assign in_acc    = smp.valid && smp.ready;
    assign store_ok  = count_reg < CNT_W'(MAX_SAMPLES);
    assign n_new     = store_ok ? count_reg + CNT_W'(1) : count_reg;
    assign pass_end  = t_reg == CNT_W'(MAX_SAMPLES - 1);
    assign last_pass = i_reg == n_reg - CNT_W'(1);
    assign off_w     = CNT_W'(MAX_SAMPLES) - n_reg;
    assign base_w    = (CNT_W+1)'(off_w) + (CNT_W+1)'(i_reg);
    assign t_ext     = (CNT_W+1)'(t_reg);
    assign k_w       = (min_len_reg == '0) ? CMP_W'(1) : CMP_W'(min_len_reg);

    assign ring_shift = (state_reg == ST_SEARCH) || (in_acc && store_ok);
    assign ring_in    = (state_reg == ST_SEARCH) ? cell_q[0] : smp.sample;

    generate
        for (genvar g = 0; g < MAX_SAMPLES; g++)
        begin : g_cell
            if (g == MAX_SAMPLES - 1)
            begin : g_tail
                msw_cell u_cell (.clk(clk), .shift(ring_shift), .d(ring_in), .q(cell_q[g]));
            end
            else
            begin : g_body
                msw_cell u_cell (.clk(clk), .shift(ring_shift), .d(cell_q[g+1]),
                                 .q(cell_q[g]));
            end
        end
    endgenerate

    assign item.vld   = (state_reg == ST_SEARCH) && (t_ext >= base_w);
    assign item.first = t_ext == base_w;
    assign item.x     = cell_q[0];
    assign item.len   = CNT_W'(t_ext - base_w + (CNT_W+1)'(1));

    msw_window u_window (.clk(clk), .rst_n(rst_n), .item(item), .k(k_w), .cand(cand));

    msw_best u_best (
        .clk(clk), .rst_n(rst_n), .clr(in_acc && smp.last), .cand(cand),
        .best_num(best_num), .best_len(best_len)
    );

    always_comb
    begin
        state_next = state_reg;
        smp.ready  = 1'b0;
        res.valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                smp.ready = 1'b1;
                if (smp.valid && smp.last)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (pass_end && last_pass)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drn_reg == DRN_W'(DRAIN_CYC - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                res.valid = 1'b1;
                if (res.ready)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            n_reg       <= '0;
            i_reg       <= '0;
            t_reg       <= '0;
            drn_reg     <= '0;
            min_len_reg <= LEN_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                min_len_reg <= cfg.data;
            end
            if (in_acc)
            begin
                count_reg <= n_new;
                if (smp.last)
                begin
                    n_reg <= n_new;
                    i_reg <= '0;
                    t_reg <= '0;
                end
            end
            if (state_reg == ST_SEARCH)
            begin
                if (pass_end)
                begin
                    t_reg <= '0;
                    i_reg <= i_reg + CNT_W'(1);
                end
                else
                begin
                    t_reg <= t_reg + CNT_W'(1);
                end
                drn_reg <= '0;
            end
            if (state_reg == ST_DRAIN)
            begin
                drn_reg <= drn_reg + DRN_W'(1);
            end
            if (res.valid && res.ready)
            begin
                count_reg <= '0;
            end
        end
    end

    assign cfg.ready = 1'b1;
    assign len_ext   = (CNT_W+LEN_W)'(best_len);

    assign res.var_numerator = (best_num > NUM_W'({OUT_NUM_W{1'b1}})) ?
                               {OUT_NUM_W{1'b1}} : best_num[OUT_NUM_W-1:0];
    assign res.window_len    = len_ext[LEN_W-1:0];
    assign res.valid_res     = best_len != '0;

`ifndef NO_ASSERTIONS
    a_res_len : assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.valid_res) |-> (res.window_len != '0))
        else $error("valid result with zero window length");

    a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
        !(smp.ready && (cand.vld || item.vld)))
        else $error("input ready while windows are in flight");

    a_count_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready) |=> (count_reg == '0 && state_reg == ST_LOAD))
        else $error("sample count not cleared after result");
`endif

endmodule
